### rtl/core/ssbi_pkg.sv
package ssbi_pkg;

    localparam int unsigned VEC_BITS    = 64;
    localparam int unsigned NUM_LANES   = 8;
    localparam int unsigned IN_TDATA_W  = 208;
    localparam int unsigned OUT_TDATA_W = 2 * VEC_BITS;

    typedef enum logic [3:0] {
        CMD_SHR_U  = 4'd0,
        CMD_SHR_S  = 4'd1,
        CMD_SHL    = 4'd2,
        CMD_RSHR_U = 4'd3,
        CMD_RSHR_S = 4'd4,
        CMD_SRA_U  = 4'd5,
        CMD_SRA_S  = 4'd6,
        CMD_RSRA_U = 4'd7,
        CMD_RSRA_S = 4'd8,
        CMD_SRI    = 4'd9,
        CMD_SLI    = 4'd10,
        CMD_SHRN   = 4'd11,
        CMD_RSHRN  = 4'd12,
        CMD_SHLL_S = 4'd13,
        CMD_SHLL_U = 4'd14
    } t_cmd;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } t_wcode;

    // How the merge stage lays lane results into the output item
    typedef enum logic [1:0] {
        PK_ELEM = 2'd0,
        PK_WIDE = 2'd1,
        PK_ZERO = 2'd2
    } t_pack;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    typedef struct packed {
        t_pack  pack;
        t_wcode wc;
        logic   last;
    } t_merge_ctl;

    typedef logic [NUM_LANES-1:0][VEC_BITS-1:0] t_lane_bus;

endpackage

### rtl/core/ssbi_lane.sv
module ssbi_lane import ssbi_pkg::*; (
    input  logic                i_clk,
    input  t_pipe_en            i_en,
    input  t_cmd                i_cmd,
    input  t_wcode              i_wc,
    input  logic [6:0]          i_n,
    input  logic [VEC_BITS-1:0] i_a,
    input  logic [VEC_BITS-1:0] i_d,
    output logic [VEC_BITS-1:0] o_res
);

    // Thermometer mask: bit i set when i < k
    function automatic logic [VEC_BITS-1:0] lowmask(input logic [6:0] k);
        logic [VEC_BITS-1:0] m;
        for (int i = 0; i < VEC_BITS; i++) begin
            m[i] = (7'(i) < k);
        end
        return m;
    endfunction

    logic [6:0]          w;
    logic [5:0]          msb_idx;
    logic                sgn_op;
    logic [VEC_BITS-1:0] sa;
    logic [VEC_BITS-1:0] x;
    logic                fill;
    logic [VEC_BITS:0]   ext;
    logic [6:0]          nc;
    logic signed [VEC_BITS:0] shr_ext;
    logic [VEC_BITS-1:0] shr;
    logic [VEC_BITS-1:0] shl;
    logic [6:0]          ridx;
    logic                rb;
    logic                big;
    logic [VEC_BITS-1:0] keep;

    logic [VEC_BITS-1:0] n_x, n_y;
    logic                n_c, n_or;
    logic [VEC_BITS-1:0] r_x, r_y;
    logic                r_c, r_or;
    logic [VEC_BITS-1:0] n_res, r_res;

    always_comb begin
        w       = 7'd8 << i_wc;
        msb_idx = 6'(w - 7'd1);
        sgn_op  = (i_cmd == CMD_SHR_S) || (i_cmd == CMD_RSHR_S) || (i_cmd == CMD_SRA_S) ||
                  (i_cmd == CMD_RSRA_S) || (i_cmd == CMD_SHLL_S);
        sa      = i_a[msb_idx] ? (i_a | ~lowmask(w)) : i_a;
        x       = sgn_op ? sa : i_a;
        fill    = sgn_op & sa[VEC_BITS-1];
        ext     = {fill, x};

        // One 65-bit arithmetic shifter covers logical, arithmetic and oversized counts
        nc      = i_n[6] ? 7'd64 : i_n;
        shr_ext = $signed(ext) >>> nc;
        shr     = shr_ext[VEC_BITS-1:0];
        shl     = i_n[6] ? '0 : (x << i_n[5:0]);

        // Rounding bit is bit (n-1); past the top it reads the fill bit
        ridx    = (i_n > 7'd64) ? 7'd64 : (i_n - 7'd1);
        rb      = (i_n == 7'd0) ? 1'b0 : ext[ridx];

        big     = (i_n >= w);
        if (big) begin
            keep = '1;
        end else if (i_cmd == CMD_SRI) begin
            keep = ~lowmask(7'(w - i_n));
        end else begin
            keep = lowmask(i_n);
        end
    end

    always_comb begin
        n_x  = '0;
        n_y  = '0;
        n_c  = 1'b0;
        n_or = 1'b0;
        unique case (i_cmd)
            CMD_SHR_U, CMD_SHR_S, CMD_SHRN: begin
                n_x = shr;
            end
            CMD_RSHR_U, CMD_RSHR_S, CMD_RSHRN: begin
                n_x = shr;
                n_c = rb;
            end
            CMD_SRA_U, CMD_SRA_S: begin
                n_x = shr;
                n_y = i_d;
            end
            CMD_RSRA_U, CMD_RSRA_S: begin
                n_x = shr;
                n_y = i_d;
                n_c = rb;
            end
            CMD_SHL, CMD_SHLL_S, CMD_SHLL_U: begin
                n_x = shl;
            end
            CMD_SRI: begin
                n_x  = big ? '0 : shr;
                n_y  = i_d & keep;
                n_or = 1'b1;
            end
            CMD_SLI: begin
                n_x  = big ? '0 : shl;
                n_y  = i_d & keep;
                n_or = 1'b1;
            end
            default: begin
                n_x = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_c  <= n_c;
            r_or <= n_or;
        end
    end

    // Second stage: accumulate with the rounding bit as carry in, or merge an insert
    assign n_res = r_or ? (r_x | r_y) : (r_x + r_y + {{(VEC_BITS-1){1'b0}}, r_c});

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/core/ssbi_merge.sv
module ssbi_merge import ssbi_pkg::*; (
    input  logic                   i_clk,
    input  t_pipe_en               i_en,
    input  t_merge_ctl             i_ctl,
    input  t_lane_bus              i_res,
    output logic [VEC_BITS-1:0]    o_lo,
    output logic [VEC_BITS-1:0]    o_hi,
    output logic                   o_last
);

    logic [2*VEC_BITS-1:0] n_out;
    logic [2*VEC_BITS-1:0] r_out;
    logic                  r_last;

    always_comb begin
        n_out = '0;
        unique case (i_ctl.pack)
            PK_ELEM: begin
                unique case (i_ctl.wc)
                    W8:  for (int e = 0; e < 8; e++) n_out[e*8 +: 8]   = i_res[e][7:0];
                    W16: for (int e = 0; e < 4; e++) n_out[e*16 +: 16] = i_res[e][15:0];
                    W32: for (int e = 0; e < 2; e++) n_out[e*32 +: 32] = i_res[e][31:0];
                    W64: n_out[VEC_BITS-1:0] = i_res[0];
                    default: n_out = '0;
                endcase
            end
            PK_WIDE: begin
                unique case (i_ctl.wc)
                    W8:  for (int e = 0; e < 8; e++) n_out[e*16 +: 16] = i_res[e][15:0];
                    W16: for (int e = 0; e < 4; e++) n_out[e*32 +: 32] = i_res[e][31:0];
                    W32, W64: for (int e = 0; e < 2; e++) n_out[e*64 +: 64] = i_res[e];
                    default: n_out = '0;
                endcase
            end
            PK_ZERO: n_out = '0;
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_out  <= n_out;
            r_last <= i_ctl.last;
        end
    end

    assign o_lo   = r_out[VEC_BITS-1:0];
    assign o_hi   = r_out[2*VEC_BITS-1:VEC_BITS];
    assign o_last = r_last;

endmodule

### rtl/core/simd_shift_by_immediate_unit_core.sv
// Vector shift-by-immediate unit: each item carries one 64-bit register cut into 8-, 16-, 32-
// or 64-bit elements and is shifted right (logical, arithmetic, rounding), left, shifted and
// accumulated into the old destination, inserted into it, narrowed from a 128-bit source or
// widened into a 128-bit result; an unknown command returns zeros. Eight lanes work on the
// elements side by side and a merge stage packs their results. The unit takes one item every
// cycle while the output is not stalled, and each result passes through two lane register
// stages (shift, then add or insert) and the output register. Back-pressure stalls only the
// stages that are full, so a new item is taken while a finished result waits for its sink.
// tlast is carried through unchanged so multi-register instructions keep their framing.
module simd_shift_by_immediate_unit_core import ssbi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // command[3:0], element_size[5:4], shift_count[12:6], source_low[76:13],
    // source_high[140:77], dest_old[204:141], zero pad[207:205]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,    // last_in
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // result_low[63:0], result_high[127:64]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast     // last_out
);

    // Pick one element of a zero-padded source, zero-extended to 64 bits
    function automatic logic [VEC_BITS-1:0] slice_elem(input logic [511:0] v,
                                                       input t_wcode c,
                                                       input logic [2:0] idx);
        logic [8:0]          base;
        logic [VEC_BITS-1:0] r;
        unique case (c)
            W8: begin
                base = {3'b000, idx, 3'b000};
                r    = {56'b0, v[base +: 8]};
            end
            W16: begin
                base = {2'b00, idx, 4'b0000};
                r    = {48'b0, v[base +: 16]};
            end
            W32: begin
                base = {1'b0, idx, 5'b00000};
                r    = {32'b0, v[base +: 32]};
            end
            W64: begin
                base = {idx, 6'b000000};
                r    = v[base +: 64];
            end
            default: begin
                base = '0;
                r    = '0;
            end
        endcase
        return r;
    endfunction

    // Input field unpacking
    t_cmd                cmd;
    t_wcode              size;
    logic [6:0]          shift_n;
    logic [VEC_BITS-1:0] src_lo, src_hi, dold;

    assign cmd     = t_cmd'(i_s_axis_tdata[3:0]);
    assign size    = t_wcode'(i_s_axis_tdata[5:4]);
    assign shift_n = i_s_axis_tdata[12:6];
    assign src_lo  = i_s_axis_tdata[76:13];
    assign src_hi  = i_s_axis_tdata[140:77];
    assign dold    = i_s_axis_tdata[204:141];

    // Pipeline control
    t_pipe_en en;
    logic     accept;
    logic     r_v1, r_v2, r_vo;

    assign en.s3           = !r_vo || i_m_axis_tready;
    assign en.s2           = !r_v2 || en.s3;
    assign en.s1           = !r_v1 || en.s2;
    assign o_s_axis_tready = en.s1;
    assign accept          = i_s_axis_tvalid && en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= accept;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_vo <= r_v2;
        end
    end

    // Decode: lane width, operand width and how results are packed
    t_wcode     eff, wc, owc;
    logic       narrow;
    t_merge_ctl ctl0, r_ctl1, r_ctl2;

    always_comb begin
        eff    = (size == W64) ? W32 : size;
        wc     = size;
        owc    = size;
        narrow = 1'b0;
        ctl0.pack = PK_ZERO;
        unique case (cmd)
            CMD_SHR_U, CMD_SHR_S, CMD_SHL, CMD_RSHR_U, CMD_RSHR_S, CMD_SRA_U, CMD_SRA_S,
            CMD_RSRA_U, CMD_RSRA_S, CMD_SRI, CMD_SLI: begin
                ctl0.pack = PK_ELEM;
            end
            CMD_SHRN, CMD_RSHRN: begin
                // Source elements are twice the result width, taken from both halves
                ctl0.pack = PK_ELEM;
                wc        = eff;
                narrow    = 1'b1;
                unique case (eff)
                    W8:      owc = W16;
                    W16:     owc = W32;
                    default: owc = W64;
                endcase
            end
            CMD_SHLL_S, CMD_SHLL_U: begin
                ctl0.pack = PK_WIDE;
                wc        = eff;
                owc       = eff;
            end
            default: begin
                ctl0.pack = PK_ZERO;
            end
        endcase
        ctl0.wc   = wc;
        ctl0.last = i_s_axis_tlast;
    end

    // Hold the merge control alongside the two lane stages
    always_ff @(posedge i_clk) begin
        if (en.s1) r_ctl1 <= ctl0;
        if (en.s2) r_ctl2 <= r_ctl1;
    end

    // Operand distribution
    logic [511:0] src_pad, dold_pad;
    t_lane_bus    lane_a, lane_d, lane_res;

    assign src_pad  = {384'b0, (narrow ? src_hi : {VEC_BITS{1'b0}}), src_lo};
    assign dold_pad = {448'b0, dold};

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_a[g] = slice_elem(src_pad, owc, 3'(g));
        assign lane_d[g] = slice_elem(dold_pad, wc, 3'(g));

        ssbi_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_cmd (cmd),
            .i_wc  (wc),
            .i_n   (shift_n),
            .i_a   (lane_a[g]),
            .i_d   (lane_d[g]),
            .o_res (lane_res[g])
        );
    end

    logic [VEC_BITS-1:0] res_lo, res_hi;

    ssbi_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ctl  (r_ctl2),
        .i_res  (lane_res),
        .o_lo   (res_lo),
        .o_hi   (res_hi),
        .o_last (o_m_axis_tlast)
    );

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {res_hi, res_lo};

    // An accepted item always occupies the first stage on the next cycle
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted item did not enter the first stage");

    // With the output register empty nothing can block the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vo |-> o_s_axis_tready)
        else $error("input stalled with an empty output register");

    // Only widening results may carry a nonzero high half
    a_high_half_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en.s3 && (r_ctl2.pack != PK_WIDE)) |=> (res_hi == '0))
        else $error("nonzero high half on a non-widening result");

endmodule

### verif/tb_simd_shift_by_immediate_unit_core.sv
module tb_simd_shift_by_immediate_unit_core;
    import ssbi_pkg::*;

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned MAX_WAIT     = 17;
    // Three register stages; leave a few spare cycles at the end
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned MAX_REPORTS  = 10;
    // Code with no operation behind it; the unit must return zeros
    localparam logic [3:0]  CMD_UNKNOWN  = 4'd15;

    typedef struct {
        logic [3:0]  cmd;
        logic [1:0]  size;
        logic [6:0]  count;
        logic [63:0] src_lo;
        logic [63:0] src_hi;
        logic [63:0] dold;
        logic        last;
        int unsigned gap;     // idle cycles before the item is offered
        bit          drain;   // hold the item until every result is back
    } shift_item_t;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        last;
    } shift_result_t;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    logic                   s_last  = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_last;

    simd_shift_by_immediate_unit_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // command, element_size, shift_count, source_low,
                                     // source_high, dest_old, zero pad
        .i_s_axis_tlast  (s_last),   // last_in
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // result_low, result_high
        .o_m_axis_tlast  (m_last)    // last_out
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Lane arithmetic. All values live in 64-bit containers; the caller
    // masks each lane back to its width.
    // ------------------------------------------------------------------
    function automatic logic [63:0] low_ones(input int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [63:0] shr_logic(input logic [63:0] x, input int unsigned n);
        return (n >= 64) ? '0 : (x >> n);
    endfunction

    function automatic logic [63:0] shl_logic(input logic [63:0] x, input int unsigned n);
        return (n >= 64) ? '0 : (x << n);
    endfunction

    // Saturate the count at 63 so huge shifts give pure sign fill
    function automatic logic [63:0] shr_arith(input logic [63:0] x, input int unsigned n);
        int unsigned k;
        k = (n > 63) ? 63 : n;
        return $signed(x) >>> k;
    endfunction

    function automatic logic [63:0] sign_extend(input logic [63:0] x, input int unsigned w);
        if (w >= 64) return x;
        return x[w-1] ? (x | ~low_ones(w)) : (x & low_ones(w));
    endfunction

    // Round by adding the last bit shifted out; a zero count has none
    function automatic logic [63:0] round_logic(input logic [63:0] a, input int unsigned n);
        logic [63:0] rbit;
        rbit = (n == 0) ? '0 : (shr_logic(a, n - 1) & 64'd1);
        return shr_logic(a, n) + rbit;
    endfunction

    // Past the top bit the bit shifted out is the sign itself
    function automatic logic [63:0] round_arith(input logic [63:0] sa, input int unsigned n);
        logic [63:0] rbit;
        if (n == 0)
            rbit = '0;
        else if (n - 1 >= 64)
            rbit = {63'd0, sa[63]};
        else
            rbit = (sa >> (n - 1)) & 64'd1;
        return shr_arith(sa, n) + rbit;
    endfunction

    function automatic logic [63:0] lane_shift(input logic [3:0] cmd, input logic [63:0] a,
                                               input logic [63:0] d, input int unsigned w,
                                               input int unsigned n);
        logic [63:0] sa;
        sa = sign_extend(a, w);
        case (cmd)
            CMD_SHR_U:  return shr_logic(a, n);
            CMD_SHR_S:  return shr_arith(sa, n);
            CMD_SHL:    return shl_logic(a, n);
            CMD_RSHR_U: return round_logic(a, n);
            CMD_RSHR_S: return round_arith(sa, n);
            CMD_SRA_U:  return d + shr_logic(a, n);
            CMD_SRA_S:  return d + shr_arith(sa, n);
            CMD_RSRA_U: return d + round_logic(a, n);
            CMD_RSRA_S: return d + round_arith(sa, n);
            // Inserts keep the old lane whole once the count covers it
            CMD_SRI:    return (n >= w) ? d : ((d & ~low_ones(w - n)) | (a >> n));
            CMD_SLI:    return (n >= w) ? d : ((d & low_ones(n)) | (a << n));
            default:    return '0;
        endcase
    endfunction

    // Expected output item for one input item
    function automatic void predict_shift(input logic [3:0] cmd, input logic [1:0] size,
                                          input logic [6:0] count, input logic [63:0] src_lo,
                                          input logic [63:0] src_hi, input logic [63:0] dold,
                                          output logic [63:0] res_lo, output logic [63:0] res_hi);
        int unsigned w, eff, lanes, per_half, idx, n;
        logic [63:0] a, d, half, s;
        res_lo = '0;
        res_hi = '0;
        n = count;
        // Narrow and widen cap the lane code at 32 bits
        eff = (size == W64) ? 2 : size;
        if (cmd <= CMD_SLI) begin
            w = 8 << size;
            lanes = 64 / w;
            for (int e = 0; e < lanes; e++) begin
                a = (src_lo >> (e * w)) & low_ones(w);
                d = (dold >> (e * w)) & low_ones(w);
                res_lo |= (lane_shift(cmd, a, d, w, n) & low_ones(w)) << (e * w);
            end
        end else if (cmd == CMD_SHRN || cmd == CMD_RSHRN) begin
            w = 8 << eff;
            lanes = 64 / w;
            per_half = 32 / w;
            for (int e = 0; e < lanes; e++) begin
                half = (e < per_half) ? src_lo : src_hi;
                idx = (e < per_half) ? e : e - per_half;
                a = (half >> (idx * 2 * w)) & low_ones(2 * w);
                s = (cmd == CMD_SHRN) ? shr_logic(a, n) : round_logic(a, n);
                res_lo |= (s & low_ones(w)) << (e * w);
            end
        end else if (cmd == CMD_SHLL_S || cmd == CMD_SHLL_U) begin
            w = 8 << eff;
            lanes = 64 / w;
            per_half = 32 / w;
            for (int e = 0; e < lanes; e++) begin
                a = (src_lo >> (e * w)) & low_ones(w);
                if (cmd == CMD_SHLL_S)
                    a = sign_extend(a, w);
                s = shl_logic(a, n) & low_ones(2 * w);
                if (e < per_half)
                    res_lo |= s << (e * 2 * w);
                else
                    res_hi |= s << ((e - per_half) * 2 * w);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store and its helpers
    // ------------------------------------------------------------------
    shift_item_t send_q[$];

    task automatic queue_item(input logic [3:0] cmd, input logic [1:0] size,
                              input logic [6:0] count, input logic [63:0] src_lo,
                              input logic [63:0] src_hi, input logic [63:0] dold,
                              input logic last, input int unsigned gap, input bit drain);
        shift_item_t it;
        it.cmd    = cmd;
        it.size   = size;
        it.count  = count;
        it.src_lo = src_lo;
        it.src_hi = src_hi;
        it.dold   = dold;
        it.last   = last;
        it.gap    = gap;
        it.drain  = drain;
        send_q.push_back(it);
    endtask

    // Random vector biased toward sign and carry corners
    function automatic logic [63:0] rand_vec();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom(), $urandom()} | 64'h8080_8080_8080_8080;
            3:       return {$urandom(), $urandom()} & 64'h7f7f_7f7f_7f7f_7f7f;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: pop the next item, sit out its gap, then offer it until taken
    // ------------------------------------------------------------------
    shift_item_t staged;
    bit          staged_ok = 1'b0;
    int unsigned gap_left  = 0;
    int unsigned pending   = 0;   // results still owed; updated by the scoreboard

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (!staged_ok && send_q.size() != 0) begin
                staged    = send_q.pop_front();
                staged_ok = 1'b1;
                gap_left  = staged.gap;
            end
            // A drain item waits for an idle cycle with nothing owed, so the
            // count of pending results already includes the previous item
            if (staged_ok && gap_left == 0 && (!staged.drain || (!s_valid && pending == 0))) begin
                s_valid   <= 1'b1;
                s_data    <= {3'b000, staged.dold, staged.src_hi, staged.src_lo,
                              staged.count, staged.size, staged.cmd};
                s_last    <= staged.last;
                staged_ok = 1'b0;
            end else begin
                s_valid <= 1'b0;
                if (staged_ok && gap_left != 0)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink: after each taken result, draw a stall; mode changes every 128
    // results so there are stretches of full throughput and of heavy stall
    // ------------------------------------------------------------------
    int unsigned sink_wait  = 0;
    int unsigned sink_taken = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (m_ready && m_valid) begin
            sink_taken++;
            case ((sink_taken / 128) % 3)
                0:       sink_wait = 0;
                1:       sink_wait = $urandom_range(0, MAX_WAIT);
                default: sink_wait = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(1, MAX_WAIT) : 0;
            endcase
            m_ready <= (sink_wait == 0);
        end else if (!m_ready) begin
            if (sink_wait == 0)
                m_ready <= 1'b1;
            else
                sink_wait--;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on every taken input item, compare every taken result
    // ------------------------------------------------------------------
    shift_result_t expected_q[$];
    int unsigned   items_in    = 0;
    int unsigned   results_out = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   failures    = 0;
    logic [15:0]   cmds_seen   = '0;
    logic [3:0]    sizes_seen  = '0;

    always @(posedge i_clk) begin : scoreboard
        shift_result_t want;
        logic [63:0]   lo, hi;
        bit            in_fire, out_fire;
        if (i_rst_n) begin
            in_fire  = s_valid && s_ready;
            out_fire = m_valid && m_ready;
            if (in_fire) begin
                predict_shift(s_data[3:0], s_data[5:4], s_data[12:6], s_data[76:13],
                              s_data[140:77], s_data[204:141], lo, hi);
                want.lo   = lo;
                want.hi   = hi;
                want.last = s_last;
                expected_q.push_back(want);
                cmds_seen[s_data[3:0]]  = 1'b1;
                sizes_seen[s_data[5:4]] = 1'b1;
            end
            if (out_fire) begin
                results_out++;
                if (expected_q.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("unexpected result %0d: lo %h hi %h last %b",
                                 results_out, m_data[63:0], m_data[127:64], m_last);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data[63:0] !== want.lo || m_data[127:64] !== want.hi ||
                        m_last !== want.last) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display({"result %0d mismatch: lo exp %h got %h, ",
                                      "hi exp %h got %h, last exp %b got %b"},
                                     results_out, want.lo, m_data[63:0], want.hi,
                                     m_data[127:64], want.last, m_last);
                    end
                end
            end
            pending     <= expected_q.size();
            items_in    <= items_in + in_fire;
            idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
    end

    // Stop a hung run: nothing moved on either side for too long
    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corners, then random multi-register frames
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned total_items, n_directed, n_random, frame_len, span, eff, count, gap;
        logic [3:0]  cmd;
        logic [1:0]  size;
        logic        last;
        bit          noise, resize;

        // Plain shifts at both ends of the count range
        queue_item(CMD_SHR_U,  W8,  7'd0,   '1, '0, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_SHR_S,  W8,  7'd8,   64'h8080_7f7f_ff00_0180, '0, '0, 1'b1, 0, 1'b0);
        queue_item(CMD_SHL,    W64, 7'd64,  '1, '0, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_SHL,    W8,  7'd7,   '1, '0, '0, 1'b1, 0, 1'b0);
        // Rounding by zero passes the lane; past the width it rounds with the sign
        queue_item(CMD_RSHR_U, W16, 7'd0,   64'hffff_8000_7fff_0001, '0, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_RSHR_S, W32, 7'd33,  64'h8000_0000_7fff_ffff, '0, '0, 1'b1, 0, 1'b0);
        queue_item(CMD_RSHR_U, W64, 7'd64,  '1, '0, '0, 1'b0, 0, 1'b0);
        // Accumulate with wrap into an all-ones destination
        queue_item(CMD_SRA_U,  W64, 7'd1,   '1, '0, '1, 1'b0, 0, 1'b0);
        queue_item(CMD_SRA_S,  W16, 7'd127, 64'h8000_7fff_ffff_0001, '0, '1, 1'b1, 0, 1'b0);
        queue_item(CMD_RSRA_U, W8,  7'd9,   '1, '0, 64'h0102_0304_0506_0708, 1'b0, 0, 1'b0);
        queue_item(CMD_RSRA_S, W64, 7'd64,  64'h8000_0000_0000_0000, '0, '1, 1'b0, 0, 1'b0);
        queue_item(CMD_RSRA_S, W8,  7'd1,   64'h7f80_ff01_7f80_ff01, '0, '1, 1'b1, 0, 1'b0);
        // Inserts: a full-width count leaves the destination untouched
        queue_item(CMD_SRI,    W8,  7'd8,   '1, '0, 64'h0123_4567_89ab_cdef, 1'b0, 0, 1'b0);
        queue_item(CMD_SRI,    W16, 7'd0,   64'h0123_4567_89ab_cdef, '0, '1, 1'b0, 0, 1'b0);
        queue_item(CMD_SLI,    W32, 7'd5,   '1, '0, 64'h0123_4567_89ab_cdef, 1'b0, 0, 1'b0);
        queue_item(CMD_SLI,    W64, 7'd63,  '1, '0, '1, 1'b1, 0, 1'b0);
        // Narrowing, including the 64-bit code that falls back to 32-bit lanes
        queue_item(CMD_SHRN,   W64, 7'd16,  64'h0123_4567_89ab_cdef, '1, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_SHRN,   W8,  7'd16,  '1, '1, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_RSHRN,  W8,  7'd1,   '1, 64'h8001_7fff_0001_ffff, '0, 1'b1, 0, 1'b0);
        queue_item(CMD_RSHRN,  W32, 7'd64,  '1, '1, '0, 1'b0, 0, 1'b0);
        // Widening, signed and unsigned, up to the result lane width
        queue_item(CMD_SHLL_S, W64, 7'd3,   64'h8000_0000_7fff_ffff, '0, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_SHLL_S, W8,  7'd16,  '1, '0, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_SHLL_U, W32, 7'd64,  '1, '0, '0, 1'b0, 0, 1'b0);
        queue_item(CMD_SHLL_U, W16, 7'd15,  '1, '0, '0, 1'b1, 0, 1'b0);
        // Unknown code returns zeros but keeps the frame marker
        queue_item(CMD_UNKNOWN, W64, 7'd127, '1, '1, '1, 1'b1, 0, 1'b0);
        n_directed = send_q.size();

        // Random frames of one to four registers sharing an operation;
        // one frame in ten is noise with a scrambled operation and tlast
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            noise     = ($urandom_range(0, 9) == 0);
            frame_len = $urandom_range(1, 4);
            resize    = 1'b1;
            for (int k = 0; k < frame_len && n_random < RANDOM_ITEMS; k++) begin
                if (resize) begin
                    cmd  = ($urandom_range(0, 19) == 0) ? CMD_UNKNOWN : 4'($urandom_range(0, 14));
                    size = 2'($urandom_range(0, 3));
                    eff  = (size == W64) ? 2 : size;
                    // Counts gather around the width that matters for this operation
                    span = (cmd >= CMD_SHRN && cmd != CMD_UNKNOWN) ? (16 << eff) : (8 << size);
                    case ($urandom_range(0, 9))
                        0:       count = $urandom_range(0, 127);
                        1:       count = span - 1;
                        2:       count = span;
                        3:       count = span + 1;
                        default: count = $urandom_range(0, span);
                    endcase
                    resize = noise;
                end
                last = noise ? 1'($urandom_range(0, 1)) : (k == frame_len - 1);
                case ((n_random / 150) % 3)
                    0:       gap = 0;
                    1:       gap = $urandom_range(0, MAX_WAIT);
                    default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
                endcase
                queue_item(cmd, size, 7'(count), rand_vec(), rand_vec(), rand_vec(), last,
                           gap, (n_random % 400 == 0));
                n_random++;
            end
        end
        total_items = send_q.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is taken and every result checked
        while (items_in != total_items || pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d directed corners, %0d in random frames), %0d results.",
                 items_in, n_directed, n_random, results_out);
        $display("Exercised %0d of 16 command codes and %0d of 4 element size codes.",
                 $countones(cmds_seen), $countones(sizes_seen));
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
